// ===== sv/lcdr_pkg.sv =====
// Shared types and constants for the character LCD frame refresher.
`timescale 1ns / 1ps

package lcdr_pkg;

    localparam int DEF_COLUMNS = 20;
    localparam int DEF_ROWS    = 4;

    // Cell address width covers the largest screen (40 x 4 = 160 cells).
    localparam int CELL_ADDR_W = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ADDR_CMD   = 8'h80;  // set-DDRAM-address 0
    localparam logic [7:0] BLANK_CHAR = 8'h20;  // ' '

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        PH_A0   = 4'd0,
        PH_A1   = 4'd1,
        PH_A2   = 4'd2,
        PH_A3   = 4'd3,
        PH_IX   = 4'd4,
        PH_H0   = 4'd5,
        PH_H1   = 4'd6,
        PH_L0   = 4'd7,
        PH_L1   = 4'd8,
        PH_NX   = 4'd9,
        PH_IDLE = 4'd15
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] character;
    } item_t;

    typedef struct packed {
        logic       rs_pin;
        logic       en_pin;
        logic [3:0] data_pins;
        logic       refresh_busy;
    } result_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic [1:0]             action;
        logic [CELL_ADDR_W-1:0] cell_addr;
        logic [7:0]             character;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== sv/char_lcd_frame_refresher_top.sv =====
// Top level of the character LCD frame refresher.
`timescale 1ns / 1ps

// Keeps a COLUMNS x ROWS character screen store (reset to all spaces) and
// drives a 4-bit character LCD from it, one sequencer step per tick item.
// Each item gives exactly one result with the RS, EN and D4..D7 levels after
// that item and a busy flag. A write item stores a character (rows 1 and 2
// swapped, coordinates clamped to the last cell); a start item restarts the
// refresh at the address command; a tick item advances one step.
// Throughput is one item per clock while neither side stalls: the front end
// classifies an item and queues it in a two-entry command queue, the back end
// runs the sequencer and the result register, so the input side keeps taking
// transfers while a result waits, until the queue is full. An item passes
// through the queue register and then the result register before its result
// is valid. The screen store is a RAM with registered read; it is read ahead
// at the next character position, with a bypass for a write to that cell and
// per-cell valid flops so that no clearing pass is needed after reset.

module char_lcd_frame_refresher_top #(
    parameter int COLUMNS = lcdr_pkg::DEF_COLUMNS,
    parameter int ROWS    = lcdr_pkg::DEF_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lcdr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output lcdr_pkg::result_t result
);

    import lcdr_pkg::*;

    cmd_t        front_cmd;
    cmd_t        head_cmd;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;

    // Front: accept transfer, map coordinates to a cell address.
    lcdr_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (front_cmd)
    );

    // Decoupling queue.
    lcdr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .q_stat  (q_stat)
    );

    // Back: store, sequencer, result register.
    lcdr_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // Queue status is never both full and empty.
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // Back end only pops a queued command.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // An enable pulse in progress means the sequencer is not idle.
    a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.en_pin) |-> result.refresh_busy)
        else $error("enable high while refresh idle");

    // A push into a full queue is never made.
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");
`endif

endmodule

// ===== sv/lcdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lcdr_front.sv =====
// Front end: accepts items and maps write coordinates to a cell address.
`timescale 1ns / 1ps

module lcdr_front #(
    parameter int COLUMNS = lcdr_pkg::DEF_COLUMNS,
    parameter int ROWS    = lcdr_pkg::DEF_ROWS
) (
    input  logic                 item_valid,
    output logic                 item_stall,
    input  lcdr_pkg::item_t      item,
    input  lcdr_pkg::queue_stat_t q_stat,
    output logic                 push,
    output lcdr_pkg::cmd_t       cmd
);

    import lcdr_pkg::*;

    logic [7:0]  row_swap;
    logic [7:0]  row_clamp;
    logic [7:0]  col_clamp;
    logic [15:0] offset;

    // Rows 1 and 2 trade places, then both coordinates clamp to the last cell.
    always_comb
    begin
        if (item.row == 8'd2)
        begin
            row_swap = 8'd1;
        end
        else if (item.row == 8'd1)
        begin
            row_swap = 8'd2;
        end
        else
        begin
            row_swap = item.row;
        end
        row_clamp = (row_swap >= 8'(ROWS)) ? 8'(ROWS - 1) : row_swap;
        col_clamp = (item.column >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : item.column;
        offset    = 16'(row_clamp) * 16'(COLUMNS) + 16'(col_clamp);
    end

    assign item_stall    = q_stat.full;
    assign push          = item_valid && !q_stat.full;
    assign cmd.action    = item.action;
    assign cmd.cell_addr = offset[CELL_ADDR_W-1:0];
    assign cmd.character = item.character;

endmodule

// ===== sv/lcdr_queue.sv =====
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module lcdr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcdr_pkg::cmd_t        cmd_in,
    input  logic                  pop,
    output lcdr_pkg::cmd_t        cmd_out,
    output lcdr_pkg::queue_stat_t q_stat
);

    import lcdr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out      = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== sv/lcdr_back.sv =====
// Back end: screen store, refresh sequencer and the result register.
`timescale 1ns / 1ps

module lcdr_back #(
    parameter int COLUMNS = lcdr_pkg::DEF_COLUMNS,
    parameter int ROWS    = lcdr_pkg::DEF_ROWS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdr_pkg::cmd_t        cmd,
    input  lcdr_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lcdr_pkg::result_t     result
);

    import lcdr_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int POS_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [POS_W:0] CELLS_W = (POS_W + 1)'(CELLS);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               rs_reg,    rs_next;
    logic               en_reg,    en_next;
    logic [3:0]         data_reg,  data_next;
    logic [CELLS-1:0]   valid_reg, valid_next;
    logic               byp_valid_reg, byp_valid_next;
    logic [7:0]         byp_data_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic               is_tick;
    logic               is_write;
    logic               is_start;
    logic [POS_W-1:0]   cell_addr;
    logic [7:0]         rd_data;
    logic [7:0]         cell_val;
    logic               last_cell;

    assign pop       = !q_stat.empty && (!result_valid_reg || !result_stall);
    assign is_tick   = pop && (cmd.action == ACT_TICK);
    assign is_write  = pop && (cmd.action == ACT_WRITE);
    assign is_start  = pop && (cmd.action == ACT_START);
    assign cell_addr = cmd.cell_addr[POS_W-1:0];
    assign last_cell = ({1'b0, pos_reg} + 1'b1) >= CELLS_W;

    // Store read runs every cycle at the next position; a write to that same
    // cell is forwarded through the bypass, and an unwritten cell reads blank.
    lcdr_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (is_write),
        .wr_addr (cell_addr),
        .wr_data (cmd.character),
        .rd_addr (pos_next),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (byp_valid_reg)
        begin
            cell_val = byp_data_reg;
        end
        else if (valid_reg[pos_reg])
        begin
            cell_val = rd_data;
        end
        else
        begin
            cell_val = BLANK_CHAR;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_start)
        begin
            phase_next = PH_A0;
        end
        else if (is_tick)
        begin
            unique case (phase_reg)
                PH_A0:   phase_next = PH_A1;
                PH_A1:   phase_next = PH_A2;
                PH_A2:   phase_next = PH_A3;
                PH_A3:   phase_next = PH_IX;
                PH_IX:   phase_next = PH_H0;
                PH_H0:   phase_next = PH_H1;
                PH_H1:   phase_next = PH_L0;
                PH_L0:   phase_next = PH_L1;
                PH_L1:   phase_next = PH_NX;
                PH_NX:   phase_next = last_cell ? PH_IDLE : PH_H0;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Pin levels and position per step
    always_comb
    begin
        rs_next   = rs_reg;
        en_next   = en_reg;
        data_next = data_reg;
        pos_next  = pos_reg;
        if (is_tick)
        begin
            unique case (phase_reg) inside
                PH_A0:
                begin
                    rs_next   = 1'b0;
                    data_next = ADDR_CMD[7:4];
                    en_next   = 1'b1;
                end
                PH_A2:
                begin
                    data_next = ADDR_CMD[3:0];
                    en_next   = 1'b1;
                end
                PH_IX:
                begin
                    pos_next = '0;
                end
                PH_H0:
                begin
                    rs_next   = 1'b1;
                    data_next = cell_val[7:4];
                    en_next   = 1'b1;
                end
                PH_L0:
                begin
                    data_next = cell_val[3:0];
                    en_next   = 1'b1;
                end
                PH_A1, PH_A3, PH_H1, PH_L1:
                begin
                    en_next = 1'b0;
                end
                PH_NX:
                begin
                    pos_next = last_cell ? '0 : pos_reg + 1'b1;
                end
                default:
                begin
                    en_next = en_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (is_write)
        begin
            valid_next[cell_addr] = 1'b1;
        end
    end

    assign byp_valid_next = is_write && (cell_addr == pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            pos_reg          <= '0;
            rs_reg           <= 1'b0;
            en_reg           <= 1'b0;
            data_reg         <= '0;
            valid_reg        <= '0;
            byp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            rs_reg        <= rs_next;
            en_reg        <= en_next;
            data_reg      <= data_next;
            valid_reg     <= valid_next;
            byp_valid_reg <= byp_valid_next;
            if (pop)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= cmd.character;
        if (pop)
        begin
            result_reg.rs_pin       <= rs_next;
            result_reg.en_pin       <= en_next;
            result_reg.data_pins    <= data_next;
            result_reg.refresh_busy <= (phase_next != PH_IDLE);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== verif/lcdr_checker.sv =====
// Checker for the character LCD frame refresher: pin-level prediction and compare.
`timescale 1ns / 1ps

module lcdr_checker #(
    parameter int COLUMNS = lcdr_pkg::DEF_COLUMNS,
    parameter int ROWS    = lcdr_pkg::DEF_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  lcdr_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  lcdr_pkg::result_t result,
    output int                fail_count,
    output int                pending
);

    import lcdr_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // shadow of the block
    phase_t     seq_phase;
    logic [6:0] cell_pos;
    logic [7:0] screen [0:CELLS-1];
    logic       rs_lvl;
    logic       en_lvl;
    logic [3:0] data_lvl;

    result_t    pins_due [$];
    int         errors = 0;
    int         waiting = 0;

    assign fail_count = errors;
    assign pending    = waiting;

    function automatic logic [7:0] cell_code(input logic [6:0] pos);
        if (pos >= CELLS)
            return BLANK_CHAR;
        return screen[pos];
    endfunction

    task automatic step_sequencer();
        logic [7:0] code;
        code = cell_code(cell_pos);
        case (seq_phase)
            PH_A0:
            begin
                rs_lvl    = 1'b0;
                data_lvl  = ADDR_CMD[7:4];
                en_lvl    = 1'b1;
                seq_phase = PH_A1;
            end
            PH_A1:
            begin
                en_lvl    = 1'b0;
                seq_phase = PH_A2;
            end
            PH_A2:
            begin
                data_lvl  = ADDR_CMD[3:0];
                en_lvl    = 1'b1;
                seq_phase = PH_A3;
            end
            PH_A3:
            begin
                en_lvl    = 1'b0;
                seq_phase = PH_IX;
            end
            PH_IX:
            begin
                cell_pos  = '0;
                seq_phase = PH_H0;
            end
            PH_H0:
            begin
                rs_lvl    = 1'b1;
                data_lvl  = code[7:4];
                en_lvl    = 1'b1;
                seq_phase = PH_H1;
            end
            PH_H1:
            begin
                en_lvl    = 1'b0;
                seq_phase = PH_L0;
            end
            PH_L0:
            begin
                data_lvl  = code[3:0];
                en_lvl    = 1'b1;
                seq_phase = PH_L1;
            end
            PH_L1:
            begin
                en_lvl    = 1'b0;
                seq_phase = PH_NX;
            end
            PH_NX:
            begin
                if (int'(cell_pos) + 1 >= CELLS)
                begin
                    cell_pos  = '0;
                    seq_phase = PH_IDLE;
                end
                else
                begin
                    cell_pos  = cell_pos + 7'd1;
                    seq_phase = PH_H0;
                end
            end
            default:
                seq_phase = PH_IDLE;
        endcase
    endtask

    task automatic store_character(input item_t it);
        int col;
        int rw;
        col = it.column;
        rw  = it.row;
        // display rows 1 and 2 are swapped in memory
        if (rw == 2)
            rw = 1;
        else if (rw == 1)
            rw = 2;
        if (col >= COLUMNS)
            col = COLUMNS - 1;
        if (rw >= ROWS)
            rw = ROWS - 1;
        screen[rw * COLUMNS + col] = it.character;
    endtask

    function automatic bit field_bad(input string name, input int want, input int got);
        if (want == got)
            return 1'b0;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : model
        result_t want;
        bit      bad;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            cell_pos  = '0;
            for (int i = 0; i < CELLS; i++)
                screen[i] = BLANK_CHAR;
            rs_lvl    = 1'b0;
            en_lvl    = 1'b0;
            data_lvl  = '0;
            pins_due.delete();
            waiting   = 0;
        end
        else
        begin
            // result side first: a result never belongs to the transfer of the same edge
            if (result_valid && !result_stall)
            begin
                if (pins_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %p", $time, result);
                    errors++;
                end
                else
                begin
                    want = pins_due.pop_front();
                    bad  = field_bad("rs_pin", want.rs_pin, result.rs_pin);
                    bad |= field_bad("en_pin", want.en_pin, result.en_pin);
                    bad |= field_bad("data_pins", want.data_pins, result.data_pins);
                    bad |= field_bad("refresh_busy", want.refresh_busy, result.refresh_busy);
                    if (bad)
                        errors++;
                end
            end
            if (item_valid && !item_stall)
            begin
                case (item.action)
                    ACT_TICK:  step_sequencer();
                    ACT_WRITE: store_character(item);
                    ACT_START: seq_phase = PH_A0;
                    default:   ;  // unused code, no effect
                endcase
                want.rs_pin       = rs_lvl;
                want.en_pin       = en_lvl;
                want.data_pins    = data_lvl;
                want.refresh_busy = (seq_phase != PH_IDLE);
                pins_due.push_back(want);
            end
            waiting = pins_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the character LCD frame refresher: stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lcdr_pkg::*;

    // action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // one full refresh: 4 address steps, index step, 5 steps per cell
    localparam int FRAME_TICKS = 5 + 5 * DEF_COLUMNS * DEF_ROWS;
    localparam int RANDOM_ITEMS = 1700;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int      fail_count;
    int      pending;
    int      sent = 0;     // counted transfers, unused codes excluded
    bit      no_idle = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    char_lcd_frame_refresher_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lcdr_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Result side back-pressure: about 11% stall, none during the quiet stretch.
    always @(posedge clk)
    begin
        result_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 11);
    end

    // Present one transfer, with an optional random gap first. Called and
    // returns at a rising edge. Stall is looked at on the falling edge, where
    // everything has settled, so the transfer is known to land on the next edge.
    task automatic send_item(input logic [1:0] act, input logic [7:0] col,
                             input logic [7:0] rw, input logic [7:0] ch);
        bit taken;
        while (!no_idle && $urandom_range(0, 99) < 11)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.action    <= act;
        item.column    <= col;
        item.row       <= rw;
        item.character <= ch;
        forever
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
            if (taken)
                break;
        end
        if (act != ACT_UNUSED)
            sent++;
    endtask

    // Hold the input side until every expected result has come back.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Coordinates: mostly around the screen edges, sometimes any byte.
    function automatic logic [7:0] pick_column();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, DEF_COLUMNS + 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_row();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, DEF_ROWS));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_write();
        send_item(ACT_WRITE, pick_column(), pick_row(), 8'($urandom_range(0, 255)));
    endtask

    // Non-write items carry random junk in the other fields.
    task automatic send_plain(input logic [1:0] act);
        send_item(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        int left;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        send_plain(ACT_TICK);                          // tick while idle
        send_plain(ACT_UNUSED);                        // unused code while idle
        send_item(ACT_WRITE, 8'd0, 8'd0, 8'h00);       // first cell, lowest code
        send_item(ACT_WRITE, 8'hFF, 8'hFF, 8'hFF);     // both coordinates clamped
        send_item(ACT_WRITE, 8'd19, 8'd1, 8'h41);      // row 1 lands in row 2
        send_item(ACT_WRITE, 8'd20, 8'd2, 8'h5A);      // row 2 lands in row 1, column clamp
        send_item(ACT_WRITE, 8'd7, 8'd3, 8'hA5);
        send_item(ACT_WRITE, 8'h80, 8'd4, 8'h7E);      // row just past the end
        send_plain(ACT_START);
        repeat (6) send_plain(ACT_TICK);               // address nibbles, index, first H0
        send_item(ACT_WRITE, 8'd0, 8'd0, 8'hC3);       // cell 0 rewritten between its nibbles
        repeat (3) send_plain(ACT_TICK);
        send_plain(ACT_START);                         // restart mid-frame
        send_plain(ACT_UNUSED);                        // unused code while busy
        repeat (4) send_plain(ACT_TICK);

        // sender holds off until the pipe is empty
        drain();

        // ---- random part ----
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // quiet stretch: no gaps on either side
            no_idle = (sent >= 500 && sent < 900);
            if ($urandom_range(0, 99) < 60)
            begin
                // full frame with writes sprinkled in, running into idle
                send_plain(ACT_START);
                left = FRAME_TICKS + $urandom_range(0, 12);
                while (left > 0 && sent < RANDOM_ITEMS)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 18)
                        send_write();
                    else if (r < 21)
                        send_plain(ACT_UNUSED);
                    else
                    begin
                        send_plain(ACT_TICK);
                        left--;
                    end
                end
            end
            else
            begin
                // short noisy burst, restarts included
                left = $urandom_range(3, 60);
                repeat (left)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        send_plain(ACT_TICK);
                    else if (r < 75)
                        send_write();
                    else if (r < 85)
                        send_plain(ACT_START);
                    else
                        send_plain(ACT_UNUSED);
                end
            end
            if ($urandom_range(0, 99) < 10)
                drain();
        end
        no_idle = 1'b0;

        // ---- wind-down ----
        drain();
        repeat (10) @(posedge clk);   // catch any stray result after the last one
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
